// ===== hdl/duplicate_message_cache_assert.svh =====
// Assertion macros used by the duplicate message cache checker
`ifndef DUPLICATE_MESSAGE_CACHE_ASSERT_SVH
`define DUPLICATE_MESSAGE_CACHE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dmc_pkg.sv =====
// Types, constants and helpers of the duplicate message cache
package dmc_pkg;
  localparam int unsigned BucketsDef = 64;
  localparam int unsigned WaysDef    = 4;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned NodeW      = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned GraceW     = 31;
  localparam int unsigned OpW        = 2;
  localparam int unsigned PurgeW     = 3;
  localparam int unsigned TotalW     = 9;
  localparam int unsigned InDataW    = 128;
  localparam int unsigned OutDataW   = 16;
  localparam logic [GraceW-1:0] GraceRst = 31'd128;

  typedef enum logic [OpW-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_GRACE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic [TotalW-1:0] total;
    logic              over;
    logic [PurgeW-1:0] purged;
    logic              in_grace;
    logic              found;
  } result_t;

  function automatic logic [KeyW-1:0] mul31(input logic [KeyW-1:0] x);
    return (x << 5) - x;
  endfunction
endpackage

// ===== hdl/duplicate_message_cache.sv =====
// Duplicate message cache: hashed set-associative key table with expiry
//
//  channel   | dir | handshake                    | payload
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata key/times, tuser op
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata result flags and total
//  grace     | in  | grace_we_i                   | grace_wdata_i
//
//  One transaction at a time. Lookup and insert pass HASH1, HASH2, the reciprocal residue
//  unit, READ and EVAL (insert also WRITE); grace check HASH1 and GCHK; unused op HASH1 only.
//  Each bucket row is read once through one memory port and written back once on insert.
//  Reset clears valid bits, entry count and output valid; the table needs no clearing pass.
//  A stalled result holds in the output register while the next transaction is taken.
module duplicate_message_cache #(
  parameter int unsigned BUCKETS = dmc_pkg::BucketsDef,
  parameter int unsigned WAYS    = dmc_pkg::WaysDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // message_number, origin_id, attester_id, broadcast_time, now_time
  input  logic [dmc_pkg::InDataW-1:0]   s_axis_tdata,
  // op
  input  logic [dmc_pkg::OpW-1:0]       s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // found, in_grace, purged_count, overflow_replaced, entry_total, zero pad
  output logic [dmc_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          grace_we_i,
  input  logic [dmc_pkg::GraceW-1:0]    grace_wdata_i
);
  import dmc_pkg::*;

  localparam int unsigned Entries = BUCKETS * WAYS;
  localparam int unsigned BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned AW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned WayW    = KeyW + 2 * NodeW + TimeW + AW;
  localparam int unsigned RowW    = WAYS * WayW;
  localparam int unsigned HW      = $clog2(Entries + 1);
  localparam int unsigned PCW     = $clog2(WAYS + 1);
  localparam int unsigned NodesLo = KeyW;
  localparam int unsigned StampLo = KeyW + 2 * NodeW;
  localparam int unsigned AgeLo   = StampLo + TimeW;
  localparam int unsigned ModSh   = KeyW + ((BUCKETS > 1) ? $clog2(BUCKETS) : 0);
  localparam int unsigned ProdW   = 2 * KeyW + 1;
  localparam logic [KeyW:0] RecipM =
    (KeyW+1)'(((64'd1 << ModSh) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HASH1 = 4'd1;
  localparam logic [3:0] S_HASH2 = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_READ  = 4'd4;
  localparam logic [3:0] S_EVAL  = 4'd5;
  localparam logic [3:0] S_WRITE = 4'd6;
  localparam logic [3:0] S_GCHK  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [GraceW-1:0]     grace_q;
  logic [OpW-1:0]        op_q;
  logic [KeyW-1:0]       msg_q;
  logic [2*NodeW-1:0]    nodes_q;
  logic [TimeW-1:0]      bt_q, now_q;
  logic [KeyW-1:0]       h_q, h_d;
  logic [ProdW-1:0]      prod_q, prod_d;
  logic [BW-1:0]         rem_q, rem_d;
  logic [1:0]            cnt_q, cnt_d;
  logic [WAYS-1:0]       valid_q [BUCKETS];
  logic [WAYS-1:0]       keep_q, keep_d;
  logic [PCW-1:0]        purged_q, purged_d;
  logic [HW-1:0]         held_q, held_d;
  result_t               res_q, res_d;
  result_t               out_q;
  logic                  out_vld_q;
  logic                  out_load;
  logic [WAYS-1:0]       vrow, vnew;
  logic                  valid_we;
  logic [BW-1:0]         bucket;
  logic [RowW-1:0]       rd_row, wr_row;
  logic                  ram_re, ram_we;
  logic [AW-1:0]         rank [WAYS];
  logic [AW-1:0]         slot;
  logic                  over;
  logic [PCW-1:0]        keep_cnt;
  logic [TimeW-1:0]      mag;

  assign bucket        = rem_q;
  assign vrow          = valid_q[bucket];
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_load      = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);
  assign ram_re        = (state_q == S_READ);
  assign ram_we        = (state_q == S_WRITE);
  assign valid_we      = ram_we;

  dmc_ram #(.WIDTH(RowW), .DEPTH(BUCKETS)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bucket),
    .wdata_i (wr_row),
    .re_i    (ram_re),
    .raddr_i (bucket),
    .rdata_o (rd_row)
  );

  always_comb begin
    logic [TimeW-1:0]  age;
    logic              any;
    logic [PCW-1:0]    np;
    logic [AW-1:0]     rk;
    logic [AW-1:0]     oldest;
    logic [TimeW-1:0]  diff;
    logic [KeyW+15:0]  plo;
    logic [KeyW+16:0]  phi;
    logic [KeyW-1:0]   quo;
    state_d  = state_q;
    h_d      = h_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    keep_d   = keep_q;
    purged_d = purged_q;
    held_d   = held_q;
    res_d    = res_q;
    vnew     = vrow;
    wr_row   = rd_row;
    over     = 1'b0;
    slot     = '0;
    keep_cnt = '0;
    oldest   = '0;
    mag      = '0;
    age      = '0;
    any      = 1'b0;
    np       = '0;
    diff     = '0;
    plo      = '0;
    phi      = '0;
    quo      = '0;
    for (int w = 0; w < WAYS; w++) begin
      rk = '0;
      for (int v = 0; v < WAYS; v++) begin
        if (v != w && keep_q[v] &&
            rd_row[v*WayW+AgeLo +: AW] < rd_row[w*WayW+AgeLo +: AW]) begin
          rk = rk + 1'b1;
        end
      end
      rank[w] = rk;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_HASH1;
        end
      end
      S_HASH1: begin
        res_d = '0;
        res_d.total = TotalW'(held_q);
        unique case (op_q)
          OP_LOOKUP, OP_INSERT: begin
            h_d     = mul31(msg_q) + KeyW'(nodes_q[2*NodeW-1:NodeW]);
            state_d = S_HASH2;
          end
          OP_GRACE: begin
            h_d     = now_q - bt_q;
            state_d = S_GCHK;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_HASH2: begin
        h_d     = mul31(h_q) + KeyW'(nodes_q[NodeW-1:0]);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_MOD;
      end
      S_MOD: begin
        if (cnt_q == 2'd0) begin
          plo    = {16'd0, h_q} * {32'd0, RecipM[15:0]};
          prod_d = ProdW'(plo);
        end else if (cnt_q == 2'd1) begin
          phi    = {17'd0, h_q} * {32'd0, RecipM[KeyW:16]};
          prod_d = prod_q + {phi, 16'd0};
        end else begin
          quo     = KeyW'(prod_q >> ModSh);
          rem_d   = h_q[BW-1:0] - BW'(quo[BW-1:0] * BUCKETS);
          state_d = S_READ;
        end
        cnt_d = cnt_q + 2'd1;
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (op_q == OP_LOOKUP) begin
          any = 1'b0;
          for (int w = 0; w < WAYS; w++) begin
            if (vrow[w] && rd_row[w*WayW +: KeyW] == msg_q &&
                rd_row[w*WayW+NodesLo +: 2*NodeW] == nodes_q) begin
              any = 1'b1;
            end
          end
          res_d.found = any;
          state_d     = S_DONE;
        end else begin
          np = '0;
          for (int w = 0; w < WAYS; w++) begin
            age = now_q - rd_row[w*WayW+StampLo +: TimeW];
            keep_d[w] = vrow[w];
            if (vrow[w] && age > TimeW'(grace_q)) begin
              keep_d[w] = 1'b0;
              np = np + 1'b1;
            end
          end
          purged_d = np;
          state_d  = S_WRITE;
        end
      end
      S_WRITE: begin
        over = &keep_q;
        for (int w = 0; w < WAYS; w++) begin
          if (keep_q[w]) begin
            keep_cnt = keep_cnt + 1'b1;
          end
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
          if (!keep_q[w]) begin
            slot = AW'(w);
          end
          if (keep_q[w] && PCW'(rank[w]) == keep_cnt - 1'b1) begin
            oldest = AW'(w);
          end
        end
        if (over) begin
          slot = oldest;
        end
        vnew = keep_q;
        for (int w = 0; w < WAYS; w++) begin
          wr_row[w*WayW+AgeLo +: AW] = rank[w] + 1'b1;
        end
        vnew[slot] = 1'b1;
        wr_row[slot*WayW +: WayW] = {AW'(0), bt_q, nodes_q, msg_q};
        held_d = held_q - HW'(purged_q) + HW'(!over);
        res_d.purged = PurgeW'(purged_q);
        res_d.over   = over;
        res_d.total  = TotalW'(held_d);
        state_d      = S_DONE;
      end
      S_GCHK: begin
        diff = h_q;
        mag  = diff[TimeW-1] ? (~diff + 1'b1) : diff;
        res_d.in_grace = (mag <= TimeW'(grace_q));
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      grace_q   <= GraceRst;
      held_q    <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        valid_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      if (grace_we_i) begin
        grace_q <= grace_wdata_i;
      end
      if (valid_we) begin
        valid_q[bucket] <= vnew;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q    <= s_axis_tuser;
      msg_q   <= s_axis_tdata[31:0];
      nodes_q <= {s_axis_tdata[47:32], s_axis_tdata[63:48]};
      bt_q    <= s_axis_tdata[95:64];
      now_q   <= s_axis_tdata[127:96];
    end
    h_q      <= h_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    keep_q   <= keep_d;
    purged_q <= purged_d;
    res_q    <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q};
endmodule

// ===== hdl/dmc_ram.sv =====
// Generic single-port-write, registered-read RAM
module dmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/dmc_checker.sv =====
// Port-level checker for the duplicate message cache, with its bind
`include "duplicate_message_cache_assert.svh"
module dmc_checker #(
  parameter int unsigned WAYS = dmc_pkg::WaysDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [dmc_pkg::OutDataW-1:0] m_axis_tdata
);
  import dmc_pkg::*;

  result_t res;
  assign res = m_axis_tdata[$bits(result_t)-1:0];

  `DMC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `DMC_ASSERT_NOW(a_flags_excl, m_axis_tvalid,
                  $onehot0({res.found, res.in_grace, (res.purged != '0) || res.over}),
                  "result flags of different ops set together")
  `DMC_ASSERT_NOW(a_purge_bound, m_axis_tvalid,
                  32'(res.purged) <= WAYS, "more entries purged than ways")
endmodule

bind duplicate_message_cache dmc_checker #(.WAYS(WAYS)) u_dmc_checker (.*);

// ===== sim/tb_duplicate_message_cache.sv =====
// Testbench of the duplicate message cache: directed table, random traffic, predictor check
`timescale 1ns / 100ps

module tb_duplicate_message_cache;
  import dmc_pkg::*;

  localparam int unsigned Entries = BucketsDef * WaysDef;
  localparam int unsigned CycleLimit = 600000;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [KeyW-1:0]  msg;
    logic [NodeW-1:0] origin;
    logic [NodeW-1:0] attester;
    logic [TimeW-1:0] bcast;
    logic [TimeW-1:0] now;
    bit               typed;
    result_t          res;
  } msg_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [OpW-1:0]      s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                grace_we_i;
  logic [GraceW-1:0]   grace_wdata_i;

  // cache shadow
  logic [KeyW-1:0]   sh_msg[Entries];
  logic [KeyW-1:0]   sh_nodes[Entries];
  logic [TimeW-1:0]  sh_stamp[Entries];
  bit                sh_valid[Entries];
  int unsigned       sh_age[Entries];
  logic [TotalW-1:0] sh_held;
  logic [GraceW-1:0] sh_grace;

  result_t   pending_results[$];
  msg_item_t directed_rows[$];
  msg_item_t pool[32];
  int unsigned errors;
  int unsigned cycles;
  bit hold_rx;

  duplicate_message_cache dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .grace_we_i(grace_we_i), .grace_wdata_i(grace_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic result_t cache_apply(msg_item_t it);
    result_t r;
    logic [KeyW-1:0] h;
    logic [KeyW-1:0] nodes;
    int unsigned base, slot, oldest, rk;
    int unsigned rank[WaysDef];
    bit have_old;
    r = '0;
    nodes = {it.origin, it.attester};
    h = it.msg * 32'd31 + {16'd0, it.origin};
    h = h * 32'd31 + {16'd0, it.attester};
    base = (h % BucketsDef) * WaysDef;
    slot = WaysDef;
    oldest = 0;
    have_old = 0;
    case (it.op)
      OP_LOOKUP: begin
        for (int w = 0; w < WaysDef; w++)
          if (sh_valid[base+w] && sh_msg[base+w] == it.msg && sh_nodes[base+w] == nodes)
            r.found = 1'b1;
      end
      OP_INSERT: begin
        for (int w = 0; w < WaysDef; w++)
          if (sh_valid[base+w] && (it.now - sh_stamp[base+w]) > {1'b0, sh_grace}) begin
            sh_valid[base+w] = 0;
            r.purged = r.purged + 1'b1;
            if (sh_held > 0) sh_held = sh_held - 1'b1;
          end
        for (int w = 0; w < WaysDef; w++) begin
          rk = 0;
          if (sh_valid[base+w])
            for (int v = 0; v < WaysDef; v++)
              if (v != w && sh_valid[base+v] && sh_age[base+v] < sh_age[base+w]) rk++;
          rank[w] = rk;
        end
        for (int w = 0; w < WaysDef; w++) begin
          if (sh_valid[base+w]) begin
            sh_age[base+w] = rank[w];
            if (!have_old || rank[w] > sh_age[base+oldest]) begin
              oldest = w;
              have_old = 1;
            end
          end else if (slot == WaysDef) begin
            slot = w;
          end
        end
        if (slot == WaysDef) begin
          slot = oldest;
          r.over = 1'b1;
          sh_valid[base+slot] = 0;
        end else begin
          sh_held = sh_held + 1'b1;
        end
        for (int w = 0; w < WaysDef; w++)
          if (sh_valid[base+w]) sh_age[base+w]++;
        sh_msg[base+slot] = it.msg;
        sh_nodes[base+slot] = nodes;
        sh_stamp[base+slot] = it.bcast;
        sh_valid[base+slot] = 1;
        sh_age[base+slot] = 0;
      end
      OP_GRACE: begin
        h = it.now - it.bcast;
        if (h[31]) h = ~h + 1;
        r.in_grace = (h <= {1'b0, sh_grace});
      end
      default: ;
    endcase
    r.total = sh_held;
    return r;
  endfunction

  function automatic msg_item_t mk(logic [OpW-1:0] op, logic [KeyW-1:0] msg,
                                   logic [NodeW-1:0] org, logic [NodeW-1:0] att,
                                   logic [TimeW-1:0] bt, logic [TimeW-1:0] now, bit typed,
                                   bit fnd, bit gr, logic [PurgeW-1:0] pc, bit ov,
                                   logic [TotalW-1:0] tot);
    msg_item_t it;
    it.op = op; it.msg = msg; it.origin = org; it.attester = att;
    it.bcast = bt; it.now = now; it.typed = typed;
    it.res.found = fnd; it.res.in_grace = gr; it.res.purged = pc;
    it.res.over = ov; it.res.total = tot;
    return it;
  endfunction

  task automatic send_item(msg_item_t it);
    int unsigned gap;
    result_t r;
    gap = $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.now, it.bcast, it.attester, it.origin, it.msg};
    s_axis_tuser <= it.op;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    r = cache_apply(it);
    pending_results.push_back(it.typed ? it.res : r);
  endtask

  task automatic write_grace(logic [GraceW-1:0] g);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    grace_we_i <= 1'b1;
    grace_wdata_i <= g;
    @(posedge clk_i);
    grace_we_i <= 1'b0;
    sh_grace = g;
  endtask

  // receiver
  initial begin
    result_t got, want;
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 11);
      if (stall > 0 || hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_rx) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk_i); while (!m_axis_tvalid);
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      @(posedge clk_i);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
          errors++;
        end
        if (got.in_grace !== want.in_grace) begin
          $display("%0t: in_grace expected %0d actual %0d", $time, want.in_grace, got.in_grace);
          errors++;
        end
        if (got.purged !== want.purged) begin
          $display("%0t: purged expected %0d actual %0d", $time, want.purged, got.purged);
          errors++;
        end
        if (got.over !== want.over) begin
          $display("%0t: overflow expected %0d actual %0d", $time, want.over, got.over);
          errors++;
        end
        if (got.total !== want.total) begin
          $display("%0t: total expected %0d actual %0d", $time, want.total, got.total);
          errors++;
        end
      end
    end
  end

  // long receiver hold-off to back up the input
  initial begin
    hold_rx = 1'b0;
    repeat (3000) @(negedge clk_i);
    hold_rx = 1'b1;
    repeat (400) @(negedge clk_i);
    hold_rx = 1'b0;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb_duplicate_message_cache: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [GraceW-1:0] grace_set[6];
    msg_item_t it;
    logic [TimeW-1:0] tick;
    int unsigned sel;
    errors = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    grace_we_i = 1'b0;
    grace_wdata_i = '0;
    sh_grace = GraceRst;
    sh_held = '0;
    for (int e = 0; e < Entries; e++) begin
      sh_valid[e] = 0;
      sh_age[e] = 0;
      sh_msg[e] = '0;
      sh_nodes[e] = '0;
      sh_stamp[e] = '0;
    end
    for (int k = 0; k < 32; k++) begin
      pool[k].msg = {26'($urandom_range(0, 32'h3FFFFFF)), 6'(3 + 20 * (k % 4))};
      pool[k].origin = 16'($urandom);
      pool[k].attester = {10'($urandom), 6'(32'd0 - pool[k].origin * 32'd31)};
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all lookup and insert keys below with origin 0 and attester 0 fall in bucket 5
    directed_rows.push_back(mk(OP_LOOKUP, 5, 0, 0, 0, 1000, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_NONE, 5, 0, 0, 0, 1000, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_GRACE, 0, 0, 0, 872, 1000, 1, 0, 1, 0, 0, 0));
    directed_rows.push_back(mk(OP_GRACE, 0, 0, 0, 871, 1000, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_GRACE, 0, 0, 0, 32'h8000_0000, 0, 1, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_GRACE, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 1, 0, 0, 0));
    directed_rows.push_back(mk(OP_INSERT, 5, 0, 0, 1000, 1000, 1, 0, 0, 0, 0, 1));
    directed_rows.push_back(mk(OP_LOOKUP, 5, 0, 0, 0, 1000, 1, 1, 0, 0, 0, 1));
    directed_rows.push_back(mk(OP_INSERT, 5, 0, 0, 1001, 1001, 1, 0, 0, 0, 0, 2));
    directed_rows.push_back(mk(OP_INSERT, 69, 0, 0, 1002, 1002, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_INSERT, 133, 0, 0, 1003, 1003, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_INSERT, 197, 0, 0, 1004, 1004, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_LOOKUP, 5, 0, 0, 0, 1004, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_INSERT, 261, 0, 0, 2000, 2000, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0, 0,
                               0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0, 0,
                               0, 0, 0, 0, 0, 0));
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    grace_set = '{GraceRst, 31'd0, 31'h7FFF_FFFF, 31'd40, 31'd600, 31'($urandom)};
    tick = $urandom;
    foreach (grace_set[p]) begin
      write_grace(grace_set[p]);
      for (int n = 0; n < 322; n++) begin
        tick = tick + $urandom_range(0, 60);
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          it = pool[$urandom_range(0, 31)];
        end else begin
          it.msg = $urandom;
          it.origin = 16'($urandom);
          it.attester = 16'($urandom);
        end
        it.typed = 0;
        it.res = '0;
        it.now = ($urandom_range(0, 9) == 0) ? $urandom : tick;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          it.op = OP_INSERT;
          it.bcast = ($urandom_range(0, 9) == 0) ? $urandom : it.now - $urandom_range(0, 50);
        end else if (sel < 75) begin
          it.op = OP_LOOKUP;
          it.bcast = $urandom;
        end else if (sel < 95) begin
          it.op = OP_GRACE;
          case ($urandom_range(0, 3))
            0: it.bcast = it.now - {1'b0, sh_grace} + $urandom_range(0, 2) - 1;
            1: it.bcast = it.now + {1'b0, sh_grace} + $urandom_range(0, 2) - 1;
            2: it.bcast = it.now - 32'h8000_0000;
            default: it.bcast = $urandom;
          endcase
        end else begin
          it.op = OP_NONE;
          it.bcast = $urandom;
        end
        send_item(it);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_duplicate_message_cache: PASS");
    end else begin
      $display("tb_duplicate_message_cache: FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dmc_pkg.sv
hdl/dmc_ram.sv
hdl/duplicate_message_cache.sv
hdl/dmc_checker.sv
sim/tb_duplicate_message_cache.sv
